/* design/nntt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nntt_pkg
// Types and constants shared by the nearest-neighbour track table.
// ---------------------------------------------------------------------------
package nntt_pkg;

    localparam int COORD_BITS = 13;
    localparam int ID_W   = 16;
    localparam int STEP_W = 14;
    localparam int DIST_W = 32;
    localparam int SPD_W  = 16;
    localparam int CNT_W  = 6;
    localparam int MISS_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MMQ8  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPDQ8 = 2'd3;

    localparam logic OP_DET = 1'b0;
    localparam logic OP_EOF = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [COORD_BITS-1:0] centre_x;
        logic [COORD_BITS-1:0] centre_y;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [ID_W-1:0]   track_id;
        logic              opened_new;
        logic              no_slot;
        logic [STEP_W-1:0] step_units;
        logic [DIST_W-1:0] distance_mm;
        logic [SPD_W-1:0]  speed_centi_kmh;
        logic [CNT_W-1:0]  live_tracks;
        logic [CNT_W-1:0]  dropped_tracks;
    } out_item_t;

    // start/done handshake to the square root unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } sqrt_ctl_t;

endpackage

/* design/nntt_isqrt.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nntt_isqrt
// Bit-serial floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module nntt_isqrt import nntt_pkg::*; #(
    parameter int IN_W = 28
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [IN_W-1:0]     radicand,
    output sqrt_ctl_t           ctl,
    output logic [IN_W/2-1:0]   root
);
    localparam int RW = IN_W / 2;
    localparam int CW = $clog2(RW + 1);

    logic [IN_W-1:0] rem_reg, rem_next;
    logic [IN_W-1:0] res_reg, res_next;
    logic [IN_W-1:0] bit_reg, bit_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(IN_W-2){1'b0}}};
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= res_reg + bit_reg) begin
                rem_next = rem_reg - (res_reg + bit_reg);
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign root      = res_reg[RW-1:0];

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start) else $error("sqrt restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("sqrt done without work");
    a_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(done_reg && busy_reg)) else $error("sqrt done while busy");
`endif

endmodule

/* design/nearest_neighbour_track_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_neighbour_track_table
// Greedy nearest-neighbour tracker over a slot table held in one memory.
//
//   channel   ports            direction  content
//   input     s_valid/s_ready  in         detection or end of frame
//   result    m_valid/m_ready  out        one result per request
//   config    cfg_valid/ready  in         register index and data
//
// A detection is accepted, the slot table scanned and the best slot read
// again, then the result is given; a match adds a square root, a multiply
// and the write-back before the result.
// End of frame sweeps the memory with read and write-back overlapped,
// then gives the result.
// Flags live in flip-flops cleared by reset; the slot memory has no reset.
// One request in flight; a pending result stalls the next one in DONE.
// ---------------------------------------------------------------------------
module nearest_neighbour_track_table import nntt_pkg::*; #(
    parameter int TRACK_SLOTS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int SW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int CNTW = $clog2(TRACK_SLOTS + 1);
    localparam int SQW = 2 * COORD_BITS + 2;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ID_W-1:0]       id;
        logic [MISS_W-1:0]     missed;
        logic [DIST_W-1:0]     total_mm;
    } slot_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_RDB   = 7'b0000100,
        ST_SQRT  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_EOF   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    slot_t mem [TRACK_SLOTS];
    slot_t rd_data_reg;
    logic  rd_en;
    logic [SW-1:0] rd_addr;
    logic  wr_en;
    logic [SW-1:0] wr_addr;
    slot_t wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [TRACK_SLOTS-1:0] valid_reg, before_reg, used_reg;
    logic [11:0] gate_reg;
    logic [7:0]  maxmiss_reg;
    logic [15:0] mmq8_reg, spdq8_reg;
    logic [ID_W-1:0] nid_reg;
    in_item_t item_reg;
    out_item_t res_reg, res_next;
    logic [CNTW-1:0] idx_reg;        // issue index
    logic [SW-1:0] prev_reg;         // slot whose data is on rd_data_reg
    logic          pv_reg;           // rd_data_reg holds a scanned slot
    logic          found_reg;
    logic [SW-1:0] best_reg;
    logic [SQW-1:0] best_sq_reg;
    logic [CNTW-1:0] live_reg, drop_reg;
    logic [29:0] step_mm_reg;
    logic [1:0]  mstep_reg;
    logic [DIST_W-1:0] dist_reg;
    slot_t new_slot;
    logic [SW-1:0] best_sel;

    // squared distance of the slot on the read port
    logic [COORD_BITS-1:0] dx, dy;
    logic [SQW-1:0] sq, gate_sq;
    always_comb begin
        dx = (item_reg.centre_x[COORD_BITS-1:0] > rd_data_reg.x)
           ? item_reg.centre_x[COORD_BITS-1:0] - rd_data_reg.x
           : rd_data_reg.x - item_reg.centre_x[COORD_BITS-1:0];
        dy = (item_reg.centre_y[COORD_BITS-1:0] > rd_data_reg.y)
           ? item_reg.centre_y[COORD_BITS-1:0] - rd_data_reg.y
           : rd_data_reg.y - item_reg.centre_y[COORD_BITS-1:0];
        sq = SQW'(dx) * SQW'(dx) + SQW'(dy) * SQW'(dy);
        gate_sq = SQW'(gate_reg) * SQW'(gate_reg);
    end

    // lowest free slot
    logic free_any;
    logic [SW-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TRACK_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    sqrt_ctl_t sq_ctl;
    logic [SQW/2-1:0] root;
    logic sq_start;
    nntt_isqrt #(.IN_W(SQW)) u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand(best_sq_reg), .ctl(sq_ctl), .root(root)
    );

    logic [STEP_W-1:0] step_units;
    assign step_units = STEP_W'(root);

    logic cand;
    assign cand = pv_reg && valid_reg[prev_reg] && before_reg[prev_reg]
                && !used_reg[prev_reg];

    logic better;
    assign better = cand && sq < gate_sq && (!found_reg || sq < best_sq_reg);
    assign best_sel = better ? prev_reg : best_reg;

    logic [CNT_W-1:0] live_sat, drop_sat;
    assign live_sat = (CNTW > CNT_W && live_reg > CNTW'(63)) ? '1 : CNT_W'(live_reg);
    assign drop_sat = (CNTW > CNT_W && drop_reg > CNTW'(63)) ? '1 : CNT_W'(drop_reg);

    logic [8:0] miss_inc;
    assign miss_inc = {1'b0, rd_data_reg.missed} + 9'd1;

    logic [29:0] mm_prod;
    assign mm_prod = {16'd0, step_units} * {14'd0, mmq8_reg};

    logic [DIST_W:0] dsum;
    assign dsum = {1'b0, rd_data_reg.total_mm} + (DIST_W+1)'(step_mm_reg);
    logic [45:0] spd_prod;
    assign spd_prod = step_mm_reg * spdq8_reg;

    logic [DIST_W-1:0] dist_sat;
    logic [SPD_W-1:0]  spd_sat;
    assign dist_sat = dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
    assign spd_sat  = (spd_prod[45:8] > 38'hFFFF) ? '1 : spd_prod[23:8];

    logic last_issue;
    assign last_issue = (idx_reg == CNTW'(TRACK_SLOTS));

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_DONE);

    // frame counts are final once the sweep ends
    always_comb begin
        m_data = res_reg;
        if (item_reg.opcode == OP_EOF) begin
            m_data.live_tracks    = live_sat;
            m_data.dropped_tracks = drop_sat;
        end
    end

    always_comb begin
        new_slot.x        = item_reg.centre_x[COORD_BITS-1:0];
        new_slot.y        = item_reg.centre_y[COORD_BITS-1:0];
        new_slot.id       = nid_reg;
        new_slot.missed   = '0;
        new_slot.total_mm = '0;
    end

    always_comb begin
        state_next = state_reg;
        rd_en   = 1'b0;
        rd_addr = idx_reg[SW-1:0];
        wr_en   = 1'b0;
        wr_addr = prev_reg;
        wr_data = rd_data_reg;
        sq_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.opcode == OP_EOF) ? ST_EOF : ST_SCAN;
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (last_issue) begin
                    // fetch best slot once more for the write-back
                    rd_addr    = best_sel;
                    state_next = ST_RDB;
                end
            end
            ST_RDB: begin
                // rd_data_reg now holds best slot
                if (found_reg) begin
                    sq_start = 1'b1;
                    state_next = ST_SQRT;
                end else begin
                    if (free_any) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx;
                        wr_data = new_slot;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_SQRT: begin
                if (sq_ctl.done) state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mstep_reg == 2'd1) begin
                    wr_en   = 1'b1;
                    wr_addr = best_reg;
                    wr_data = rd_data_reg;
                    wr_data.x = item_reg.centre_x[COORD_BITS-1:0];
                    wr_data.y = item_reg.centre_y[COORD_BITS-1:0];
                    wr_data.total_mm = dist_reg;
                    state_next = ST_DONE;
                end
            end
            ST_EOF: begin
                rd_en = !last_issue;
                if (pv_reg && valid_reg[prev_reg]) begin
                    wr_en = 1'b1;
                    wr_data.missed = used_reg[prev_reg] ? '0 : miss_inc[MISS_W-1:0];
                end
                if (last_issue) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        res_next = res_reg;
        if (state_reg == ST_SQRT && sq_ctl.done) res_next.step_units = step_units;
        if (state_reg == ST_MUL && mstep_reg == 2'd0) begin
            res_next.distance_mm     = dist_sat;
            res_next.speed_centi_kmh = spd_sat;
        end
        if (state_reg == ST_RDB) begin
            res_next = '0;
            res_next.result_kind = 1'b0;
            if (found_reg) begin
                res_next.track_id = rd_data_reg.id;
            end else if (free_any) begin
                res_next.track_id   = nid_reg;
                res_next.opened_new = 1'b1;
            end else begin
                res_next.no_slot = 1'b1;
            end
        end
        if (state_reg == ST_EOF && last_issue) begin
            res_next = '0;
            res_next.result_kind = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            before_reg  <= '0;
            used_reg    <= '0;
            gate_reg    <= 12'd200;
            maxmiss_reg <= 8'd25;
            mmq8_reg    <= 16'd5760;
            spdq8_reg   <= 16'd2304;
            nid_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GATE:  gate_reg    <= cfg_data[11:0];
                    REG_MISS:  maxmiss_reg <= cfg_data[7:0];
                    REG_MMQ8:  mmq8_reg    <= cfg_data;
                    REG_SPDQ8: spdq8_reg   <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_RDB: begin
                    if (!found_reg && free_any) begin
                        valid_reg[free_idx]  <= 1'b1;
                        before_reg[free_idx] <= 1'b0;
                        used_reg[free_idx]   <= 1'b1;
                        nid_reg <= nid_reg + 1'b1;
                    end
                end
                ST_MUL: if (mstep_reg == 2'd1) used_reg[best_reg] <= 1'b1;
                ST_EOF: begin
                    if (pv_reg && valid_reg[prev_reg]) begin
                        used_reg[prev_reg] <= 1'b0;
                        if (!used_reg[prev_reg] && miss_inc > {1'b0, maxmiss_reg}) begin
                            valid_reg[prev_reg]  <= 1'b0;
                            before_reg[prev_reg] <= 1'b0;
                        end else begin
                            before_reg[prev_reg] <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        case (state_reg)
            ST_IDLE: begin
                item_reg  <= s_data;
                idx_reg   <= CNTW'(1);
                prev_reg  <= '0;
                pv_reg    <= s_valid;
                found_reg <= 1'b0;
                best_reg  <= '0;
                live_reg  <= '0;
                drop_reg  <= '0;
                mstep_reg <= '0;
            end
            ST_SCAN: begin
                if (better) begin
                    found_reg   <= 1'b1;
                    best_reg    <= prev_reg;
                    best_sq_reg <= sq;
                end
                prev_reg <= idx_reg[SW-1:0];
                pv_reg   <= !last_issue;
                if (!last_issue) idx_reg <= idx_reg + 1'b1;
            end
            ST_EOF: begin
                if (pv_reg && valid_reg[prev_reg]) begin
                    if (!used_reg[prev_reg] && miss_inc > {1'b0, maxmiss_reg})
                        drop_reg <= drop_reg + 1'b1;
                    else
                        live_reg <= live_reg + 1'b1;
                end
                prev_reg <= idx_reg[SW-1:0];
                pv_reg   <= !last_issue;
                if (!last_issue) idx_reg <= idx_reg + 1'b1;
            end
            ST_SQRT: begin
                if (sq_ctl.done) step_mm_reg <= 30'(mm_prod >> 8);
            end
            ST_MUL: begin
                mstep_reg <= mstep_reg + 1'b1;
                if (mstep_reg == 2'd0) dist_reg <= dist_sat;
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_used_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> ((used_reg & ~valid_reg) == '0))
        else $error("used slot not valid");
    a_before_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (before_reg & ~valid_reg) == '0) else $error("old slot not valid");
    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && item_reg.opcode == OP_EOF) |-> used_reg == '0)
        else $error("used flags left after frame end");
`endif

endmodule
